FILE: hw/rtl/kpt_pkg.sv
// ----------------------------------------------------------------------------
// kpt_pkg
// Shared types and constants of the key press tracker: operation codes,
// register map, configuration bundle and the layout of one count entry.
// ----------------------------------------------------------------------------
package kpt_pkg;

  // Widths fixed by the item and register formats
  localparam int unsigned KEY_W   = 8;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned EPOCH_W = 4;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  // Operation codes carried by an input transfer
  typedef enum logic [1:0] {
    OP_KEY_DOWN = 2'd0,
    OP_KEY_UP   = 2'd1,
    OP_QUERY    = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  // Register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_SHIFT_CODE   = 2'd0,
    REG_CONTROL_CODE = 2'd1,
    REG_REPEAT_LIMIT = 2'd2
  } reg_idx_t;

  // Register values seen by the tracker
  typedef struct packed {
    logic [KEY_W-1:0] shift_key_code;
    logic [KEY_W-1:0] control_key_code;
    logic [CNT_W-1:0] repeat_limit;
  } cfg_t;

  // One count entry: the count is live only while its epoch tag matches
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [CNT_W-1:0]   count;
  } entry_t;

  // Count held by an entry under the current epoch; stale entries read zero
  function automatic logic [CNT_W-1:0] entry_count(entry_t e, logic [EPOCH_W-1:0] ep);
    return (e.epoch == ep) ? e.count : '0;
  endfunction

endpackage

FILE: hw/rtl/kpt_apb_regs.sv
// ----------------------------------------------------------------------------
// kpt_apb_regs
// APB register file: shift key code, control key code and repeat limit.
// Zero-wait-state writes and reads.
// ----------------------------------------------------------------------------
module kpt_apb_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kpt_pkg::ADDR_W-1:0]   paddr,
  input  logic [kpt_pkg::DATA_W-1:0]   pwdata,
  output logic [kpt_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output kpt_pkg::cfg_t                cfg
);

  logic                wr_en;
  kpt_pkg::reg_idx_t   idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = kpt_pkg::reg_idx_t'(paddr[3:2]);

  // Write registers on a completed access transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shift_key_code   <= kpt_pkg::KEY_W'(16);
      cfg.control_key_code <= kpt_pkg::KEY_W'(17);
      cfg.repeat_limit     <= kpt_pkg::CNT_W'(4);
    end else if (wr_en) begin
      case (idx)
        kpt_pkg::REG_SHIFT_CODE:   cfg.shift_key_code   <= pwdata[kpt_pkg::KEY_W-1:0];
        kpt_pkg::REG_CONTROL_CODE: cfg.control_key_code <= pwdata[kpt_pkg::KEY_W-1:0];
        kpt_pkg::REG_REPEAT_LIMIT: cfg.repeat_limit     <= pwdata[kpt_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (idx)
      kpt_pkg::REG_SHIFT_CODE:   prdata = kpt_pkg::DATA_W'(cfg.shift_key_code);
      kpt_pkg::REG_CONTROL_CODE: prdata = kpt_pkg::DATA_W'(cfg.control_key_code);
      kpt_pkg::REG_REPEAT_LIMIT: prdata = kpt_pkg::DATA_W'(cfg.repeat_limit);
      default:                   prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/kpt_count_mem.sv
// ----------------------------------------------------------------------------
// kpt_count_mem
// Count store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kpt_count_mem #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  kpt_pkg::entry_t        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output kpt_pkg::entry_t        rdata
);

  kpt_pkg::entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/key_press_tracker.sv
// ----------------------------------------------------------------------------
// key_press_tracker
// Per-key pending press counter with shift/control filtering and a found flag.
// ----------------------------------------------------------------------------
// Each accepted command (start high while busy is low) yields exactly one
// result, shown on hit and key_found for the single cycle in which done is
// high; the receiver cannot stall it, so it must take the result in that
// cycle. Key up and an ordinary key down read the key's count, then write
// it back. A query reads the shift, control and key counts in turn from the
// one read port, then writes the key's count back. A shift or control key
// down reads the two modifier counts, gives its result, advances the epoch
// and writes both counts back one per cycle. Clear all answers in the cycle
// after it is accepted by advancing a 4-bit epoch tag kept in every entry;
// on every 16th epoch step the store is swept instead, which keeps busy
// high until every entry is cleared. After reset the same sweep runs before
// the first command is accepted; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module key_press_tracker #(
  parameter int unsigned KEY_CODES = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  // command channel
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     operation,
  input  logic [kpt_pkg::KEY_W-1:0]      key_code,
  input  logic                           want_shift,
  input  logic                           want_control,
  // result channel
  output logic                           done,
  output logic                           hit,
  output logic                           key_found,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [kpt_pkg::ADDR_W-1:0]     paddr,
  input  logic [kpt_pkg::DATA_W-1:0]     pwdata,
  output logic [kpt_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);

  localparam int unsigned AW        = $clog2(KEY_CODES);
  localparam logic        ALL_CODES = (KEY_CODES >= 256);
  localparam logic [16:0] CODE_LIM  = 17'(KEY_CODES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(KEY_CODES - 1);

  typedef enum logic [6:0] {
    ST_SWEEP    = 7'b0000001,
    ST_IDLE     = 7'b0000010,
    ST_RD_CTRL  = 7'b0000100,
    ST_RD_KEY   = 7'b0001000,
    ST_UPDATE   = 7'b0010000,
    ST_WR_SHIFT = 7'b0100000,
    ST_WR_CTRL  = 7'b1000000
  } state_t;

  // A key code has a counter only below KEY_CODES
  function automatic logic code_ok(logic [kpt_pkg::KEY_W-1:0] c);
    return ALL_CODES || ({9'd0, c} < CODE_LIM);
  endfunction

  kpt_pkg::cfg_t   cfg;
  state_t          state;
  kpt_pkg::op_t    op_q;
  logic [kpt_pkg::KEY_W-1:0]   key_q;
  logic [kpt_pkg::KEY_W-1:0]   shift_q;
  logic [kpt_pkg::KEY_W-1:0]   ctrl_q;
  logic                        want_s_q;
  logic                        want_c_q;
  logic [kpt_pkg::EPOCH_W-1:0] epoch;
  logic [kpt_pkg::CNT_W-1:0]   s_cnt;
  logic [kpt_pkg::CNT_W-1:0]   c_cnt;
  logic [kpt_pkg::CNT_W-1:0]   new_s;
  logic [kpt_pkg::CNT_W-1:0]   new_c;
  logic                        resume;
  logic [AW-1:0]               sweep_addr;
  logic                        found_flag;

  // memory port signals
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  kpt_pkg::entry_t             mem_wdata;
  logic [AW-1:0]               mem_raddr;
  kpt_pkg::entry_t             mem_rdata;

  // datapath
  logic                        accept;
  kpt_pkg::op_t                op_in;
  logic                        in_is_mod;
  logic                        in_multi;
  logic [kpt_pkg::CNT_W-1:0]   rd_cnt;
  logic [kpt_pkg::CNT_W-1:0]   s_now;
  logic [kpt_pkg::CNT_W-1:0]   c_now;
  logic [kpt_pkg::CNT_W-1:0]   k_now;
  logic [kpt_pkg::CNT_W-1:0]   mod_cnt;
  logic [kpt_pkg::CNT_W-1:0]   mod_inc;
  logic [kpt_pkg::CNT_W-1:0]   upd_cnt;
  logic                        query_match;
  logic                        epoch_wrap;

  kpt_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kpt_count_mem #(
    .DEPTH (KEY_CODES)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign op_in  = kpt_pkg::op_t'(operation);

  // Commands that need the modifier counts read first
  assign in_is_mod = (key_code == cfg.shift_key_code) || (key_code == cfg.control_key_code);
  assign in_multi  = ((op_in == kpt_pkg::OP_KEY_DOWN) && in_is_mod) ||
                     ((op_in == kpt_pkg::OP_QUERY) && (key_code != '0));

  // Decode the entry coming out of the read port
  assign rd_cnt = kpt_pkg::entry_count(mem_rdata, epoch);
  assign s_now  = code_ok(shift_q) ? rd_cnt : '0;
  assign c_now  = code_ok(ctrl_q)  ? rd_cnt : '0;
  assign k_now  = code_ok(key_q)   ? rd_cnt : '0;

  // Modifier key down: the key's count is one of the two modifier counts
  assign mod_cnt = (key_q == shift_q) ? s_cnt : c_now;
  assign mod_inc = (mod_cnt < cfg.repeat_limit) ? kpt_pkg::CNT_W'(mod_cnt + 1'b1) : mod_cnt;

  assign query_match = ((s_cnt != '0) == want_s_q) && ((c_cnt != '0) == want_c_q) &&
                       (k_now != '0);

  assign epoch_wrap = (epoch == '1);

  // New count of the key written back in the update cycle
  always_comb begin
    case (op_q)
      kpt_pkg::OP_KEY_DOWN:
        upd_cnt = (k_now < cfg.repeat_limit) ? kpt_pkg::CNT_W'(k_now + 1'b1) : k_now;
      kpt_pkg::OP_KEY_UP: upd_cnt = '0;
      kpt_pkg::OP_QUERY:  upd_cnt = query_match ? kpt_pkg::CNT_W'(k_now - 1'b1) : k_now;
      default:            upd_cnt = k_now;
    endcase
  end

  // Select the read address
  always_comb begin
    case (state)
      ST_IDLE:    mem_raddr = in_multi ? AW'(cfg.shift_key_code) : AW'(key_code);
      ST_RD_CTRL: mem_raddr = AW'(ctrl_q);
      default:    mem_raddr = AW'(key_q);
    endcase
  end

  // Drive the write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(key_q);
    mem_wdata = '0;
    case (state)
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_addr;
      end
      ST_UPDATE: begin
        mem_we          = code_ok(key_q);
        mem_wdata.epoch = epoch;
        mem_wdata.count = upd_cnt;
      end
      ST_WR_SHIFT: begin
        mem_we          = code_ok(shift_q);
        mem_waddr       = AW'(shift_q);
        mem_wdata.epoch = epoch;
        mem_wdata.count = new_s;
      end
      ST_WR_CTRL: begin
        mem_we          = code_ok(ctrl_q);
        mem_waddr       = AW'(ctrl_q);
        mem_wdata.epoch = epoch;
        mem_wdata.count = new_c;
      end
      default: ;
    endcase
  end

  // Latch the command fields on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= op_in;
      key_q    <= key_code;
      shift_q  <= cfg.shift_key_code;
      ctrl_q   <= cfg.control_key_code;
      want_s_q <= want_shift;
      want_c_q <= want_control;
    end
  end

  // Sequence reads, writes and results
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      sweep_addr <= '0;
      resume     <= 1'b0;
      epoch      <= '0;
      found_flag <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_SWEEP: begin
          // clear one entry per cycle
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == LAST_ADDR) begin
            sweep_addr <= '0;
            resume     <= 1'b0;
            state      <= resume ? ST_WR_SHIFT : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (in_multi) begin
              state <= ST_RD_CTRL;
            end else if ((op_in == kpt_pkg::OP_KEY_DOWN) || (op_in == kpt_pkg::OP_KEY_UP)) begin
              state <= ST_UPDATE;
            end else begin
              // clear all, or a query of key zero: answer at once
              done      <= 1'b1;
              hit       <= 1'b0;
              key_found <= found_flag;
              if (op_in == kpt_pkg::OP_CLEAR) begin
                if (epoch_wrap) begin
                  epoch <= '0;
                  state <= ST_SWEEP;
                end else begin
                  epoch <= epoch + 1'b1;
                end
              end
            end
          end
        end
        ST_RD_CTRL: begin
          s_cnt <= s_now;
          state <= ST_RD_KEY;
        end
        ST_RD_KEY: begin
          c_cnt <= c_now;
          if (op_q == kpt_pkg::OP_QUERY) begin
            state <= ST_UPDATE;
          end else begin
            // modifier down: keep only the two modifier counts
            new_s      <= (key_q == shift_q) ? mod_inc : s_cnt;
            new_c      <= (key_q == ctrl_q)  ? mod_inc : c_now;
            done       <= 1'b1;
            hit        <= (mod_cnt != '0);
            key_found  <= found_flag || (mod_cnt == '0);
            found_flag <= found_flag || (mod_cnt == '0);
            if (epoch_wrap) begin
              epoch  <= '0;
              resume <= 1'b1;
              state  <= ST_SWEEP;
            end else begin
              epoch <= epoch + 1'b1;
              state <= ST_WR_SHIFT;
            end
          end
        end
        ST_UPDATE: begin
          done  <= 1'b1;
          state <= ST_IDLE;
          case (op_q)
            kpt_pkg::OP_KEY_DOWN: begin
              hit        <= (k_now != '0);
              key_found  <= found_flag || (k_now == '0);
              found_flag <= found_flag || (k_now == '0);
            end
            kpt_pkg::OP_QUERY: begin
              hit        <= query_match;
              key_found  <= query_match;
              found_flag <= query_match;
            end
            default: begin
              hit       <= 1'b0;
              key_found <= found_flag;
            end
          endcase
        end
        ST_WR_SHIFT: begin
          state <= ST_WR_CTRL;
        end
        ST_WR_CTRL: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
